// File: hw/rtl/lzwenc_pkg.sv
// Shared constants and the controller/datapath interface types for the LZW encoder.
// No dependencies; every other file of the encoder imports this package.
package lzwenc_pkg;

  // Default dictionary size (total codes, roots included).
  localparam int unsigned DICT_ENTRIES_DEF = 4096;
  // Number of fixed root codes; the first free code follows them.
  localparam int unsigned ROOT_COUNT = 127;
  // Width of one input symbol.
  localparam int unsigned SYM_W = 7;
  // Width of the emitted code word.
  localparam int unsigned OUT_CODE_W = 12;
  // Width of the per-slot text generation tag in the hash table.
  localparam int unsigned EPOCH_W = 4;
  // Depth of the result queue.
  localparam int unsigned OUTQ_DEPTH = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the accepted input word
    logic set_root;     // start a prefix from the symbol's root code
    logic probe_start;  // read the hash table at the hashed key
    logic probe_next;   // read the following slot (collision)
    logic take_hit;     // prefix becomes the matching entry's code
    logic take_miss;    // emit prefix, insert entry if room, restart at root
    logic emit_last;    // emit prefix flagged as the last code
    logic restart;      // begin a new text with a fresh dictionary
    logic clear_step;   // clear one table slot
    logic clear_done;   // clearing pass finished
  } lzw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sym_zero;     // captured symbol is zero
    logic eot;          // captured word ends the text
    logic prefix_valid; // a prefix is pending
    logic slot_used;    // slot just read belongs to the current text
    logic slot_match;   // slot just read holds the current key
    logic epoch_wrap;   // generation tag is exhausted, table needs a clear
    logic clear_last;   // clearing pass is at the final slot
  } lzw_status_t;

endpackage

// File: hw/rtl/lzwenc_outq.sv
// Small result queue between the encoder datapath and the output channel.
// Depends on lzwenc_pkg for the queue depth and code width.
module lzwenc_outq (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [lzwenc_pkg::OUT_CODE_W-1:0] push_code,
  input  logic                              push_last,
  output logic                              room,
  output logic [lzwenc_pkg::OUT_CODE_W-1:0] out_code,
  output logic                              last_code,
  output logic                              code_valid,
  input  logic                              code_stall
);
  import lzwenc_pkg::*;

  localparam int unsigned PTR_W = $clog2(OUTQ_DEPTH);
  localparam int unsigned CNT_W = $clog2(OUTQ_DEPTH + 1);

  logic [OUT_CODE_W-1:0] code_mem [OUTQ_DEPTH];
  logic                  last_mem [OUTQ_DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;
  logic                  pop;

  // A word leaves when it is shown and not stalled.
  assign pop        = code_valid && !code_stall;
  assign code_valid = (count != '0);
  assign out_code   = code_mem[rd_ptr];
  assign last_code  = last_mem[rd_ptr];
  // Room for the two words a single symbol can produce.
  assign room       = (count <= CNT_W'(OUTQ_DEPTH - 2));

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      code_mem[wr_ptr] <= push_code;
      last_mem[wr_ptr] <= push_last;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // The queue must never be written while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(OUTQ_DEPTH) || pop))
    else $error("result queue overflow");

endmodule

// File: hw/rtl/lzwenc_dpath.sv
// Datapath of the LZW encoder: input capture, prefix state and the hashed dictionary.
// Depends on lzwenc_pkg for constants and the command/status structs.
module lzwenc_dpath #(
  parameter int unsigned DICT_ENTRIES = lzwenc_pkg::DICT_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lzwenc_pkg::SYM_W-1:0]      symbol,
  input  logic                              end_of_text,
  input  lzwenc_pkg::lzw_cmd_t              cmd,
  output lzwenc_pkg::lzw_status_t           status,
  output logic                              push,
  output logic [lzwenc_pkg::OUT_CODE_W-1:0] push_code,
  output logic                              push_last
);
  import lzwenc_pkg::*;

  localparam int unsigned CODE_W      = $clog2(DICT_ENTRIES);
  localparam int unsigned FREE_W      = $clog2(DICT_ENTRIES + 1);
  localparam int unsigned HASH_W      = CODE_W + 1;
  localparam int unsigned TABLE_DEPTH = 1 << HASH_W;
  localparam int unsigned KEY_W       = CODE_W + SYM_W;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [KEY_W-1:0]   key;
    logic [CODE_W-1:0]  code;
  } slot_t;

  slot_t              table_mem [TABLE_DEPTH];
  slot_t              rd_slot;
  logic [SYM_W-1:0]   sym_q;
  logic               eot_q;
  logic [CODE_W-1:0]  prefix;
  logic               prefix_valid;
  logic [FREE_W-1:0]  next_free;
  logic [EPOCH_W-1:0] epoch;
  logic [HASH_W-1:0]  probe_idx;
  logic [HASH_W-1:0]  clear_idx;

  logic [CODE_W-1:0]  root_code;
  logic [KEY_W-1:0]   key_cur;
  logic [HASH_W-1:0]  hash_idx;
  logic [HASH_W-1:0]  rd_addr;
  logic               rd_en;
  logic               dict_room;
  logic               wr_en;
  logic [HASH_W-1:0]  wr_addr;
  slot_t              wr_slot;
  logic [31:0]        prefix_wide;

  // Key, root code and hash of the current (prefix, symbol) pair.
  assign root_code = CODE_W'(sym_q - SYM_W'(1));
  assign key_cur   = {prefix, sym_q};
  assign hash_idx  = HASH_W'(prefix) ^ (HASH_W'(sym_q) << (HASH_W - SYM_W));
  assign dict_room = (next_free < FREE_W'(DICT_ENTRIES));

  // Table read port: first probe at the hash, then linear probing.
  assign rd_en   = cmd.probe_start || cmd.probe_next;
  assign rd_addr = cmd.probe_start ? hash_idx : (probe_idx + HASH_W'(1));

  // Table write port: clearing pass or insertion of a new entry.
  always_comb begin
    wr_en   = cmd.clear_step || (cmd.take_miss && dict_room);
    wr_addr = cmd.clear_step ? clear_idx : probe_idx;
    if (cmd.clear_step) begin
      wr_slot = '0;
    end else begin
      wr_slot.tag  = epoch;
      wr_slot.key  = key_cur;
      wr_slot.code = next_free[CODE_W-1:0];
    end
  end

  // Dictionary memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_slot;
    end
    if (rd_en) begin
      rd_slot <= table_mem[rd_addr];
    end
  end

  // Captured input word and probe position.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_q <= symbol;
      eot_q <= end_of_text;
    end
    if (cmd.probe_start) begin
      probe_idx <= hash_idx;
    end else if (cmd.probe_next) begin
      probe_idx <= probe_idx + HASH_W'(1);
    end
  end

  // Prefix, free code, generation tag and clear counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix       <= '0;
      prefix_valid <= 1'b0;
      next_free    <= FREE_W'(ROOT_COUNT);
      epoch        <= EPOCH_W'(1);
      clear_idx    <= '0;
    end else begin
      if (cmd.set_root) begin
        prefix       <= root_code;
        prefix_valid <= 1'b1;
      end
      if (cmd.take_hit) begin
        prefix <= rd_slot.code;
      end
      if (cmd.take_miss) begin
        prefix <= root_code;
        if (dict_room) begin
          next_free <= next_free + FREE_W'(1);
        end
      end
      if (cmd.restart) begin
        prefix       <= '0;
        prefix_valid <= 1'b0;
        next_free    <= FREE_W'(ROOT_COUNT);
        if (epoch != '1) begin
          epoch <= epoch + EPOCH_W'(1);
        end
      end
      if (cmd.clear_step) begin
        clear_idx <= clear_idx + HASH_W'(1);
      end
      if (cmd.clear_done) begin
        epoch <= EPOCH_W'(1);
      end
    end
  end

  // Result words: the pending prefix, zero-extended or truncated to the output code width.
  assign prefix_wide = 32'(prefix);
  assign push        = cmd.take_miss || cmd.emit_last;
  assign push_code   = prefix_wide[OUT_CODE_W-1:0];
  assign push_last   = cmd.emit_last;

  // Status back to the controller.
  always_comb begin
    status.sym_zero     = (sym_q == '0);
    status.eot          = eot_q;
    status.prefix_valid = prefix_valid;
    status.slot_used    = (rd_slot.tag == epoch);
    status.slot_match   = (rd_slot.key == key_cur);
    status.epoch_wrap   = (epoch == '1);
    status.clear_last   = (clear_idx == '1);
  end

  // The free code never runs past the dictionary size.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= FREE_W'(DICT_ENTRIES))
    else $error("next free code out of range");

  // A hit always names a code already handed out in this text.
  a_hit_assigned: assert property (@(posedge clk) disable iff (rst)
    cmd.take_hit |-> (FREE_W'(rd_slot.code) < next_free))
    else $error("dictionary hit on an unassigned code");

endmodule

// File: hw/rtl/lzwenc_ctrl.sv
// Controller state machine of the LZW encoder: sequences capture, probing and emission.
// Depends on lzwenc_pkg for the command/status structs.
module lzwenc_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sym_valid,
  output logic                     sym_stall,
  input  logic                     room,
  input  lzwenc_pkg::lzw_status_t  status,
  output lzwenc_pkg::lzw_cmd_t     cmd
);
  import lzwenc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECIDE,
    S_PROBE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // A word is taken only when idle and the result queue can hold two words.
  assign sym_stall = !((state == S_IDLE) && room);
  assign accept    = sym_valid && !sym_stall;

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          cmd.clear_done = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.sym_zero) begin
          // Zero symbol terminates a pending text and is otherwise ignored.
          if (status.prefix_valid) begin
            cmd.emit_last = 1'b1;
            cmd.restart   = 1'b1;
            state_next    = status.epoch_wrap ? S_CLEAR : S_IDLE;
          end else begin
            state_next = S_IDLE;
          end
        end else if (!status.prefix_valid) begin
          cmd.set_root = 1'b1;
          state_next   = S_FINISH;
        end else begin
          cmd.probe_start = 1'b1;
          state_next      = S_PROBE;
        end
      end
      S_PROBE: begin
        if (status.slot_used && status.slot_match) begin
          cmd.take_hit = 1'b1;
          state_next   = S_FINISH;
        end else if (status.slot_used) begin
          cmd.probe_next = 1'b1;
        end else begin
          cmd.take_miss = 1'b1;
          state_next    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.eot) begin
          cmd.emit_last = 1'b1;
          cmd.restart   = 1'b1;
          state_next    = status.epoch_wrap ? S_CLEAR : S_IDLE;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register; reset starts the table clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Every accepted word is decoded in the following cycle.
  a_accept_decide: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_DECIDE))
    else $error("accepted word not decoded");

  // No word may enter while the table is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_step |-> sym_stall)
    else $error("input taken during clearing pass");

endmodule

// File: hw/rtl/lzw_stream_encoder_core.sv
// LZW stream encoder top level: input word in, 0 to 2 code words out per accepted symbol.
// Each accepted symbol goes through the controller states DECIDE, then PROBE for a lookup
// (repeated per hash collision), then FINISH; a zero symbol skips PROBE and FINISH, the
// first symbol of a text skips PROBE. A new symbol is taken only in IDLE, and input also
// stalls while the output queue lacks room for two words. Reset (rst, synchronous) runs a
// clearing pass over the hash table (8192 slots by default), again after every 15th text.
module lzw_stream_encoder_core #(
  parameter int unsigned DICT_ENTRIES = lzwenc_pkg::DICT_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [lzwenc_pkg::SYM_W-1:0]      symbol,
  input  logic                              end_of_text,
  input  logic                              sym_valid,
  output logic                              sym_stall,
  output logic [lzwenc_pkg::OUT_CODE_W-1:0] out_code,
  output logic                              last_code,
  output logic                              code_valid,
  input  logic                              code_stall
);
  import lzwenc_pkg::*;

  lzw_cmd_t              cmd;
  lzw_status_t           status;
  logic                  room;
  logic                  push;
  logic [OUT_CODE_W-1:0] push_code;
  logic                  push_last;

  // Sequencer.
  lzwenc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .room      (room),
    .status    (status),
    .cmd       (cmd)
  );

  // Prefix state and dictionary.
  lzwenc_dpath #(
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .symbol      (symbol),
    .end_of_text (end_of_text),
    .cmd         (cmd),
    .status      (status),
    .push        (push),
    .push_code   (push_code),
    .push_last   (push_last)
  );

  // Output queue toward the code channel.
  lzwenc_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_code  (push_code),
    .push_last  (push_last),
    .room       (room),
    .out_code   (out_code),
    .last_code  (last_code),
    .code_valid (code_valid),
    .code_stall (code_stall)
  );

endmodule

// File: dv/tb_lzw_stream_encoder_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for lzw_stream_encoder_core: a queue-fed symbol driver, a code
// word monitor and a behavioral LZW encoder that predicts every code word.
// Depends on lzwenc_pkg and the lzw_stream_encoder_core RTL.
module tb_lzw_stream_encoder_core;
  import lzwenc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 50000;
  localparam int unsigned RANDOM_SYMBOLS  = 720;
  localparam int unsigned DRAIN_CYCLES    = 40;
  // A small dictionary so that a short text already fills it.
  localparam int unsigned TB_DICT_ENTRIES = 256;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             eot;
    logic             hold;  // wait for all pending code words before this word
  } sym_word_t;

  typedef struct packed {
    logic [OUT_CODE_W-1:0] code;
    logic                  last;
  } code_word_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [SYM_W-1:0]      symbol = '0;
  logic                  end_of_text = 1'b0;
  logic                  sym_valid = 1'b0;
  logic                  sym_stall;
  logic [OUT_CODE_W-1:0] out_code;
  logic                  last_code;
  logic                  code_valid;
  logic                  code_stall = 1'b0;

  // Stimulus and expectation stores.
  sym_word_t  pending_words[$];
  code_word_t expected_codes[$];
  sym_word_t  next_word;
  logic       sym_taken = 1'b0;

  // Behavioral encoder state.
  logic [OUT_CODE_W-1:0] enc_prefix;
  logic                  enc_live;
  int unsigned           enc_next_code;
  logic [OUT_CODE_W-1:0] dict_codes[logic [OUT_CODE_W+SYM_W-1:0]];

  // Bookkeeping.
  int unsigned errors = 0;
  int unsigned symbols_in = 0;
  int unsigned codes_checked = 0;
  int unsigned texts_done = 0;
  int unsigned dict_fills = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned stall_tick = 0;

  lzw_stream_encoder_core #(
    .DICT_ENTRIES (TB_DICT_ENTRIES)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .symbol      (symbol),
    .end_of_text (end_of_text),
    .sym_valid   (sym_valid),
    .sym_stall   (sym_stall),
    .out_code    (out_code),
    .last_code   (last_code),
    .code_valid  (code_valid),
    .code_stall  (code_stall)
  );

  always #4 clk = ~clk;

  function automatic void push_code(input logic [OUT_CODE_W-1:0] code, input logic last);
    code_word_t cw;
    cw.code = code;
    cw.last = last;
    expected_codes.push_back(cw);
  endfunction

  // Ends the current text: no prefix, fresh dictionary.
  function automatic void restart_text();
    enc_live      = 1'b0;
    enc_prefix    = '0;
    enc_next_code = ROOT_COUNT;
    dict_codes.delete();
    texts_done++;
  endfunction

  // Greedy LZW step for one accepted word; queues the code words it produces.
  function automatic void encode_symbol(input logic [SYM_W-1:0] sym, input logic eot);
    logic [OUT_CODE_W+SYM_W-1:0] key;
    key = {enc_prefix, sym};
    if (sym == '0) begin
      // A zero symbol terminates a pending text and is otherwise ignored.
      if (enc_live) begin
        push_code(enc_prefix, 1'b1);
        restart_text();
      end
    end else begin
      if (!enc_live) begin
        enc_prefix = OUT_CODE_W'(sym) - 1'b1;
        enc_live   = 1'b1;
      end else if (dict_codes.exists(key)) begin
        enc_prefix = dict_codes[key];
      end else begin
        push_code(enc_prefix, 1'b0);
        if (enc_next_code < TB_DICT_ENTRIES) begin
          dict_codes[key] = enc_next_code[OUT_CODE_W-1:0];
          enc_next_code++;
          if (enc_next_code == TB_DICT_ENTRIES) dict_fills++;
        end
        enc_prefix = OUT_CODE_W'(sym) - 1'b1;
      end
      if (eot) begin
        push_code(enc_prefix, 1'b1);
        restart_text();
      end
    end
  endfunction

  function automatic void add_word(input int unsigned sym, input bit eot, input bit hold);
    sym_word_t w;
    w.sym  = sym[SYM_W-1:0];
    w.eot  = eot;
    w.hold = hold;
    pending_words.push_back(w);
  endfunction

  // Monitor: predicts on each accepted symbol, checks each accepted code word.
  always @(posedge clk) begin
    if (rst) begin
      sym_taken   <= 1'b0;
      idle_cycles = 0;
    end else begin
      sym_taken <= sym_valid && !sym_stall;
      if (sym_valid && !sym_stall) begin
        encode_symbol(symbol, end_of_text);
        symbols_in++;
      end
      if (code_valid && !code_stall) begin
        if (expected_codes.size() == 0) begin
          $error("unexpected code word: out_code=%0d last_code=%0d", out_code, last_code);
          errors++;
        end else begin
          code_word_t exp_cw;
          exp_cw = expected_codes.pop_front();
          if (out_code !== exp_cw.code) begin
            $error("out_code: expected %0d, got %0d", exp_cw.code, out_code);
            errors++;
          end
          if (last_code !== exp_cw.last) begin
            $error("last_code: expected %0d, got %0d", exp_cw.last, last_code);
            errors++;
          end
        end
        codes_checked++;
      end
      // Watchdog on cycles in which no word moves on either side.
      if ((sym_valid && !sym_stall) || (code_valid && !code_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog: no word accepted for %0d cycles.", idle_cycles);
          $display("** lzw_stream_encoder_core: FAILED **");
          $finish;
        end
      end
    end
  end

  // Symbol driver: bursts of words with random gaps; a hold word waits for the output side.
  always @(negedge clk) begin
    if (rst) begin
      sym_valid   <= 1'b0;
      symbol      <= '0;
      end_of_text <= 1'b0;
      gap_left    = 0;
      burst_left  = 0;
    end else if (!sym_valid || sym_taken) begin
      if (gap_left != 0) begin
        gap_left--;
        sym_valid <= 1'b0;
      end else if (pending_words.size() == 0 ||
                   (pending_words[0].hold && expected_codes.size() != 0)) begin
        sym_valid <= 1'b0;
      end else begin
        next_word = pending_words.pop_front();
        symbol      <= next_word.sym;
        end_of_text <= next_word.eot;
        sym_valid   <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Output stall: switches among a few patterns, including stretches with no stall.
  always @(negedge clk) begin
    if (rst) begin
      code_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        STALL_NONE:  code_stall <= 1'b0;
        STALL_LIGHT: code_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: code_stall <= ($urandom_range(0, 9) < 7);
        default:     code_stall <= ((stall_tick % 5) < 2);
      endcase
    end
  end

  initial begin
    int unsigned rand_syms;
    int unsigned len;
    int unsigned alpha;
    int unsigned base;
    int unsigned s;
    int unsigned total_words;
    bit          hold;
    bit          eot;

    restart_text();
    texts_done = 0;

    // Directed words: single-symbol texts at both ends of the symbol range.
    add_word(1, 1, 0);
    add_word(127, 1, 0);
    // Zero symbols with no text open are ignored, whatever end_of_text says.
    add_word(0, 0, 0);
    add_word(0, 1, 0);
    // Repeating pair builds long matches; a zero symbol then closes the text.
    add_word(1, 0, 0);
    add_word(2, 0, 0);
    add_word(1, 0, 0);
    add_word(2, 0, 0);
    add_word(1, 0, 0);
    add_word(2, 0, 0);
    add_word(0, 1, 0);
    // End of text on a miss that follows a dictionary hit.
    add_word(127, 0, 0);
    add_word(127, 0, 0);
    add_word(127, 0, 0);
    add_word(127, 1, 0);
    // End of text on a miss gives two code words for one symbol.
    add_word(3, 0, 0);
    add_word(4, 1, 0);
    // Alternating bit patterns.
    add_word(85, 0, 0);
    add_word(42, 0, 0);
    add_word(85, 0, 0);
    add_word(42, 1, 0);

    // One long text whose adjacent symbol pairs are almost all new, so the
    // dictionary fills up and further misses stop adding entries.
    for (int k = 1; k <= 2; k++) begin
      for (int i = 0; i < 127; i++) begin
        s = 1 + ((k * 7 + i * k) % 127);
        add_word(s, (k == 2) && (i == 126), (k == 1) && (i == 0));
      end
    end

    // Random texts: mostly well-formed, over alphabets of varied size.
    rand_syms = 0;
    while (rand_syms < RANDOM_SYMBOLS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      case ($urandom_range(0, 4))
        0:       alpha = 1;
        1:       alpha = 2;
        2:       alpha = 3;
        3:       alpha = 8;
        default: alpha = 127;
      endcase
      base = $urandom_range(1, 128 - alpha);
      hold = ($urandom_range(0, 29) == 0);
      for (int i = 0; i < len; i++) begin
        s = base + $urandom_range(0, alpha - 1);
        // Now and then a stray zero symbol cuts the text short.
        if ($urandom_range(0, 59) == 0) s = 0;
        // Some texts run on into the next one without an end mark.
        eot = (i == len - 1) && ($urandom_range(0, 19) != 0);
        add_word(s, eot, hold && (i == 0));
        if (s != 0) rand_syms++;
      end
      if ($urandom_range(0, 9) == 0) add_word(0, $urandom_range(0, 1), 0);
    end
    total_words = pending_words.size();

    // Reset, released on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Let all words go in, all code words come out, then watch for strays.
    while (symbols_in < total_words) @(negedge clk);
    while (expected_codes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d symbols over %0d finished texts; checked %0d code words.",
             symbols_in, texts_done, codes_checked);
    $display("Dictionary reached its full size %0d time(s).", dict_fills);
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("** lzw_stream_encoder_core: PASSED **");
    end else begin
      $display("** lzw_stream_encoder_core: FAILED **");
    end
    $finish;
  end

endmodule
